// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk and switched off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) else $error(msg);

`endif

// File: hdl/rqpd_pkg.sv
package rqpd_pkg;

	// opcodes
	localparam logic OP_ENQ  = 1'b0;
	localparam logic OP_DISP = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ENQUEUED   = 2'd0;
	localparam logic [1:0] ST_DISPATCHED = 2'd1;
	localparam logic [1:0] ST_IDLE       = 2'd2;
	localparam logic [1:0] ST_REJECTED   = 2'd3;

	// policy codes, unused codes behave as round robin
	localparam logic [2:0] POL_RR   = 3'd0;
	localparam logic [2:0] POL_SJF  = 3'd1;
	localparam logic [2:0] POL_SRT  = 3'd2;
	localparam logic [2:0] POL_GUAR = 3'd3;
	localparam logic [2:0] POL_FB   = 3'd4;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         task_id;
		logic [15:0]        target_time;
		logic [15:0]        served_time;
		logic signed [15:0] priority_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         picked_id;
		logic [15:0]        picked_target;
		logic [15:0]        picked_served;
		logic signed [15:0] picked_priority;
		logic [4:0]         queue_count;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FETCH,
		S_CMP,
		S_SHSTART,
		S_SHIFT,
		S_DONE
	} state_t;

	// read address select
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_IDX1,
		RD_BEST1,
		RD_IDX2
	} rd_sel_t;

	// index register update
	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_INC,
		IDX_BEST
	} idx_op_t;

	typedef struct packed {
		logic       cap;
		logic       wr_enq;
		logic       shift_wr;
		logic       emit;
		logic [1:0] emit_status;
		logic       rd_en;
		rd_sel_t    rd_sel;
		idx_op_t    idx_op;
		logic       load_first;
		logic       load_cur;
		logic       compare;
	} ctrl_cmd_t;

	typedef struct packed {
		logic opcode;
		logic full;
		logic empty;
		logic idx_zero;
		logic scan_more;
		logic sh_start_more;
		logic sh_more;
	} dp_sts_t;

endpackage

// File: hdl/rqpd_ram.sv
module rqpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rqpd_ctrl.sv
`include "assert_macros.svh"

module rqpd_ctrl
	import rqpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.opcode == OP_ENQ) begin
					cmd.emit = 1'b1;
					if (sts.full) begin
						cmd.emit_status = ST_REJECTED;
					end else begin
						cmd.wr_enq      = 1'b1;
						cmd.emit_status = ST_ENQUEUED;
					end
					state_d = S_IDLE;
				end else if (sts.empty) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_IDLE;
					state_d         = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_ZERO;
					cmd.idx_op = IDX_ZERO;
					state_d    = S_FETCH;
				end
			end
			S_FETCH: begin
				if (sts.idx_zero) begin
					// head entry seeds the running best
					cmd.load_first = 1'b1;
					if (sts.scan_more) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_IDX1;
						cmd.idx_op = IDX_INC;
					end else begin
						state_d = S_SHSTART;
					end
				end else begin
					cmd.load_cur = 1'b1;
					state_d      = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				if (sts.scan_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX1;
					cmd.idx_op = IDX_INC;
					state_d    = S_FETCH;
				end else begin
					state_d = S_SHSTART;
				end
			end
			S_SHSTART: begin
				cmd.idx_op = IDX_BEST;
				if (sts.sh_start_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BEST1;
					state_d    = S_SHIFT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (sts.sh_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX2;
					cmd.idx_op = IDX_INC;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_DISPATCHED;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`ASSERT_IMPL(a_no_shift_and_enq, cmd.shift_wr, !cmd.wr_enq && !cmd.emit, "compaction write clashes with enqueue or emit")

endmodule

// File: hdl/rqpd_dp.sv
`include "assert_macros.svh"

module rqpd_dp
	import rqpd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_WIDTH  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      policy_we,
	input  logic [2:0] policy_wdata,
	input  in_item_t  item,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	output out_item_t result,
	output logic      done
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = TIME_WIDTH;
	localparam int PW = 2 * TIME_WIDTH;

	typedef struct packed {
		logic [3:0]    id;
		logic [TW-1:0] target;
		logic [TW-1:0] served;
		logic [15:0]   prio;
	} ent_t;

	in_item_t            in_q;
	logic [2:0]          policy_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       best_idx_q;
	ent_t                cur_q;
	ent_t                best_q;
	logic signed [TW:0]  cur_rem_q;
	logic signed [TW:0]  best_rem_q;
	logic [PW-1:0]       prod_c_q;
	logic [PW-1:0]       prod_b_q;
	out_item_t           res_q;
	logic                done_q;

	logic [CW-1:0]       idx_p1;
	logic [CW-1:0]       idx_p2;
	logic [CW-1:0]       best_p1;
	logic [CW-1:0]       cnt_inc;
	logic [CW-1:0]       cnt_dec;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	ent_t                wr_data;
	logic [AW-1:0]       rd_addr;
	ent_t                rd_data;
	logic signed [TW:0]  rd_rem;
	logic [PW-1:0]       prod_c;
	logic [PW-1:0]       prod_b;
	logic                beats;
	out_item_t           res_d;

	assign idx_p1  = idx_q + CW'(1);
	assign idx_p2  = idx_q + CW'(2);
	assign best_p1 = best_idx_q + CW'(1);
	assign cnt_inc = count_q + CW'(1);
	assign cnt_dec = count_q - CW'(1);

	assign sts.opcode        = in_q.opcode;
	assign sts.full          = (count_q == CW'(QUEUE_DEPTH));
	assign sts.empty         = (count_q == '0);
	assign sts.idx_zero      = (idx_q == '0);
	assign sts.scan_more     = (idx_p1 < count_q);
	assign sts.sh_start_more = (best_p1 < count_q);
	assign sts.sh_more       = (idx_p2 < count_q);

	// entry store
	always_comb begin
		if (cmd.shift_wr) begin
			wr_addr = idx_q[AW-1:0];
			wr_data = rd_data;
		end else begin
			wr_addr        = count_q[AW-1:0];
			wr_data.id     = in_q.task_id;
			wr_data.target = TW'(in_q.target_time);
			wr_data.served = TW'(in_q.served_time);
			wr_data.prio   = in_q.priority_level;
		end
	end
	assign wr_en = cmd.wr_enq | cmd.shift_wr;

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO:  rd_addr = '0;
			RD_IDX1:  rd_addr = idx_p1[AW-1:0];
			RD_BEST1: rd_addr = best_p1[AW-1:0];
			RD_IDX2:  rd_addr = idx_p2[AW-1:0];
			default:  rd_addr = '0;
		endcase
	end

	rqpd_ram #(
		.WIDTH ($bits(ent_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// keys of the entry just read
	assign rd_rem = signed'({1'b0, rd_data.target}) - signed'({1'b0, rd_data.served});
	assign prod_c = PW'(rd_data.served) * PW'(best_q.target);
	assign prod_b = PW'(best_q.served) * PW'(rd_data.target);

	always_comb begin
		case (policy_q)
			POL_SJF:  beats = (cur_q.target < best_q.target);
			POL_SRT:  beats = (cur_rem_q < best_rem_q);
			POL_GUAR: beats = (prod_c_q < prod_b_q);
			POL_FB:   beats = ($signed(cur_q.prio) < $signed(best_q.prio));
			default:  beats = 1'b0;
		endcase
	end

	always_comb begin
		res_d        = '0;
		res_d.status = cmd.emit_status;
		case (cmd.emit_status)
			ST_DISPATCHED: begin
				res_d.picked_id       = best_q.id;
				res_d.picked_target   = 16'(best_q.target);
				res_d.picked_served   = 16'(best_q.served);
				res_d.picked_priority = signed'(best_q.prio);
				res_d.queue_count     = 5'(cnt_dec);
			end
			ST_ENQUEUED: begin
				res_d.queue_count = 5'(cnt_inc);
			end
			default: begin
				res_d.queue_count = 5'(count_q);
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= POL_RR;
			count_q    <= '0;
			idx_q      <= '0;
			best_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (policy_we) begin
				policy_q <= policy_wdata;
			end
			if (cmd.wr_enq) begin
				count_q <= cnt_inc;
			end else if (cmd.emit && cmd.emit_status == ST_DISPATCHED) begin
				count_q <= cnt_dec;
			end
			case (cmd.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_ZERO: idx_q <= '0;
				IDX_INC:  idx_q <= idx_p1;
				IDX_BEST: idx_q <= best_idx_q;
				default:  idx_q <= idx_q;
			endcase
			if (cmd.load_first) begin
				best_idx_q <= idx_q;
			end else if (cmd.compare && beats) begin
				best_idx_q <= idx_q;
			end
			done_q <= cmd.emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			in_q <= item;
		end
		if (cmd.load_first) begin
			best_q     <= rd_data;
			best_rem_q <= rd_rem;
		end else if (cmd.compare && beats) begin
			best_q     <= cur_q;
			best_rem_q <= cur_rem_q;
		end
		if (cmd.load_cur) begin
			cur_q     <= rd_data;
			cur_rem_q <= rd_rem;
			prod_c_q  <= prod_c;
			prod_b_q  <= prod_b;
		end
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;
	assign done   = done_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "entry count above queue depth")
	`ASSERT_IMPL(a_pick_zero, done_q && res_q.status != ST_DISPATCHED,
		res_q.picked_id == '0 && res_q.picked_target == '0,
		"pick fields set on a non-dispatch result")
	`ASSERT_NEXT(a_enq_count, cmd.wr_enq, count_q == $past(cnt_inc),
		"enqueue did not advance the entry count")

endmodule

// File: hdl/ready_queue_policy_dispatcher_unit.sv
// Ready-queue dispatcher: holds up to QUEUE_DEPTH tasks in arrival order and, on a dispatch,
// removes and reports the one picked by the policy register (round robin, shortest job,
// shortest remaining, guaranteed ratio, feedback priority; ties to the earliest entry).
// A transaction is taken when start is high and busy is low; its one result appears on
// result for exactly one cycle with done high, and the receiver cannot stall it, so it
// must take every result as it comes. An enqueue or an empty dispatch ends in the decode
// state. A dispatch over queued entries first scans them all from the head: the entries
// are read one at a time through the single read port of the entry memory, each
// candidate after the head is registered with its key products and then compared, and
// the gap left by the winner is closed one entry per cycle. The policy is written through
// policy_we/policy_wdata and should only change while the block is idle.
module ready_queue_policy_dispatcher_unit
	import rqpd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_WIDTH  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// transaction in
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	// result out
	output logic       done,
	output out_item_t  result,
	// policy register
	input  logic       policy_we,
	input  logic [2:0] policy_wdata
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// sequencer: decode, scan, compaction and result timing
	rqpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// entry memory, running best, key compare and result register
	rqpd_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.done         (done)
	);

endmodule

// File: sim/tb_top.sv
module tb_top;
	import rqpd_pkg::*;

	localparam int          QUEUE_SLOTS    = 16;
	localparam int          RANDOM_ITEMS   = 1250;
	// longest quiet stretch: a full-queue dispatch plus the widest sender gap
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          DRAIN_CYCLES   = 64;
	localparam int          REPORT_CAP     = 40;
	// highest unused policy code, expected to fall back to round robin
	localparam logic [2:0]  POL_SPARE_TOP  = 3'd7;
	localparam out_item_t   NO_WANT        = '0;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// one line of the directed stimulus; want is only used where typed is set
	typedef struct {
		row_kind_t  kind;
		logic [2:0] pol;
		int         rep;
		bit         rnd;
		bit         typed;
		in_item_t   stim;
		out_item_t  want;
	} stim_row_t;

	localparam int N_DIR_ROWS = 32;

	stim_row_t dir_rows [N_DIR_ROWS] = '{
		// dispatch straight after reset finds nothing queued
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b1, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0},
			'{ST_IDLE, 4'd0, 16'd0, 16'd0, 16'sd0, 5'd0}},
		// field extremes on the way in
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b1, '{OP_ENQ, 4'd15, 16'hffff, 16'h0000, 16'sh8000},
			'{ST_ENQUEUED, 4'd0, 16'd0, 16'd0, 16'sd0, 5'd1}},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b1, '{OP_ENQ, 4'd0, 16'h0001, 16'hffff, 16'sh7fff},
			'{ST_ENQUEUED, 4'd0, 16'd0, 16'd0, 16'sd0, 5'd2}},
		'{ROW_CFG, POL_SJF, 1, 1'b0, 1'b0, '0, NO_WANT},
		// least target sits behind the head
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b1, '{OP_DISP, 4'd9, 16'h1234, 16'h4321, 16'sh5555},
			'{ST_DISPATCHED, 4'd0, 16'h0001, 16'hffff, 16'sh7fff, 5'd1}},
		'{ROW_CFG, POL_SRT, 1, 1'b0, 1'b0, '0, NO_WANT},
		// served beyond target gives a negative remainder
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_ENQ, 4'd3, 16'd5, 16'd9, 16'sd100}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_GUAR, 1, 1'b0, 1'b0, '0, NO_WANT},
		// zero targets: products collapse to zero and nobody strictly wins
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_ENQ, 4'd7, 16'd0, 16'd0, -16'sd5}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_ENQ, 4'd8, 16'd0, 16'd5, 16'sd0}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd1, 16'd2, 16'd3, 16'sd4}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_FB, 1, 1'b0, 1'b0, '0, NO_WANT},
		// equal priorities, the earlier one must go first
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_ENQ, 4'd9, 16'd20, 16'd3, -16'sd1}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_ENQ, 4'd10, 16'd20, 16'd3, -16'sd1}, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		// spare policy code falls back to the head
		'{ROW_CFG, POL_SPARE_TOP, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_RR, 1, 1'b0, 1'b0, '0, NO_WANT},
		// top the queue up to the last slot with random entries
		'{ROW_ITEM, POL_RR, 15, 1'b1, 1'b0, '0, NO_WANT},
		// no room left
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b1, '{OP_ENQ, 4'd5, 16'd77, 16'd1, 16'sd2},
			'{ST_REJECTED, 4'd0, 16'd0, 16'd0, 16'sd0, 5'd16}},
		// every policy once, starting from a full queue
		'{ROW_CFG, POL_SJF, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_SRT, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_GUAR, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_FB, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT},
		'{ROW_CFG, POL_RR, 1, 1'b0, 1'b0, '0, NO_WANT},
		'{ROW_ITEM, POL_RR, 1, 1'b0, 1'b0, '{OP_DISP, 4'd0, 16'd0, 16'd0, 16'sd0}, NO_WANT}
	};

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       start        = 1'b0;
	logic       busy;
	in_item_t   item         = '0;
	logic       done;
	out_item_t  result;
	logic       policy_we    = 1'b0;
	logic [2:0] policy_wdata = '0;

	// shadow of the ready queue, in arrival order
	logic [3:0]         shadow_id     [QUEUE_SLOTS];
	logic [15:0]        shadow_target [QUEUE_SLOTS];
	logic [15:0]        shadow_served [QUEUE_SLOTS];
	logic signed [15:0] shadow_prio   [QUEUE_SLOTS];
	int                 shadow_count  = 0;
	logic [2:0]         shadow_policy = POL_RR;

	// predicted outcomes of accepted transactions, oldest first
	out_item_t predicted_outcomes [$];

	int mismatch_count = 0;
	int stall_cycles   = 0;
	int burst_left     = 0;

	ready_queue_policy_dispatcher_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.done         (done),
		.result       (result),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("mismatch %s: got %0h want %0h", what, got, want);
		end
	endtask

	// strict win of queued entry c over the current best b; equal keys keep b
	function automatic bit outranks(int c, int b);
		int          rem_c;
		int          rem_b;
		logic [31:0] cross_c;
		logic [31:0] cross_b;
		case (shadow_policy)
			POL_SJF: return shadow_target[c] < shadow_target[b];
			POL_SRT: begin
				rem_c = shadow_target[c];
				rem_c = rem_c - shadow_served[c];
				rem_b = shadow_target[b];
				rem_b = rem_b - shadow_served[b];
				return rem_c < rem_b;
			end
			POL_GUAR: begin
				// served ratio compared by cross products, no division
				cross_c = 32'(shadow_served[c]) * 32'(shadow_target[b]);
				cross_b = 32'(shadow_served[b]) * 32'(shadow_target[c]);
				return cross_c < cross_b;
			end
			POL_FB: return shadow_prio[c] < shadow_prio[b];
			default: return 1'b0;
		endcase
	endfunction

	// applies one transaction to the shadow queue and returns what the block should report
	function automatic out_item_t schedule_step(in_item_t it);
		out_item_t r;
		int        best;
		r = '0;
		if (it.opcode == OP_ENQ) begin
			if (shadow_count >= QUEUE_SLOTS) begin
				r.status = ST_REJECTED;
			end else begin
				shadow_id[shadow_count]     = it.task_id;
				shadow_target[shadow_count] = it.target_time;
				shadow_served[shadow_count] = it.served_time;
				shadow_prio[shadow_count]   = it.priority_level;
				shadow_count++;
				r.status = ST_ENQUEUED;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_IDLE;
		end else begin
			best = 0;
			for (int i = 1; i < shadow_count; i++) begin
				if (outranks(i, best)) best = i;
			end
			r.status          = ST_DISPATCHED;
			r.picked_id       = shadow_id[best];
			r.picked_target   = shadow_target[best];
			r.picked_served   = shadow_served[best];
			r.picked_priority = shadow_prio[best];
			// close the gap, arrival order kept
			for (int i = best; i + 1 < shadow_count; i++) begin
				shadow_id[i]     = shadow_id[i + 1];
				shadow_target[i] = shadow_target[i + 1];
				shadow_served[i] = shadow_served[i + 1];
				shadow_prio[i]   = shadow_prio[i + 1];
			end
			shadow_count--;
		end
		r.queue_count = 5'(shadow_count);
		return r;
	endfunction

	// random task entry or dispatch; a quarter use narrow values so ties turn up often
	function automatic in_item_t random_task_entry(int enq_pct);
		in_item_t it;
		it.opcode  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DISP;
		it.task_id = 4'($urandom_range(15));
		if ($urandom_range(3) == 0) begin
			it.target_time    = 16'($urandom_range(3));
			it.served_time    = 16'($urandom_range(3));
			it.priority_level = 16'($urandom_range(2)) - 16'sd1;
		end else begin
			it.target_time    = 16'($urandom);
			it.served_time    = 16'($urandom);
			it.priority_level = 16'($urandom);
		end
		return it;
	endfunction

	// offer one transaction and hold it until the block takes it
	task automatic issue_command(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t predicted;
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = schedule_step(it);
		predicted_outcomes.push_back(typed ? want : predicted);
	endtask

	// sender works in bursts: long runs back to back, then a random pause
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(30, 8)) @(posedge clk);
			end else begin
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
			burst_left = ($urandom_range(2) == 0) ? $urandom_range(60, 20) : $urandom_range(8);
		end
	endtask

	// policy only changes with the block idle and nothing outstanding
	task automatic write_policy(input logic [2:0] pol);
		start <= 1'b0;
		do @(posedge clk); while (predicted_outcomes.size() != 0 || busy);
		repeat (2) @(posedge clk);
		policy_we    <= 1'b1;
		policy_wdata <= pol;
		@(posedge clk);
		shadow_policy = pol;
		policy_we <= 1'b0;
	endtask

	// result side: every done pulse is one transaction result, checked field by field
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (predicted_outcomes.size() == 0) begin
				report_mismatch("unexpected result", result, '0);
			end else begin
				want = predicted_outcomes.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.picked_id !== want.picked_id)
					report_mismatch("picked_id", result.picked_id, want.picked_id);
				if (result.picked_target !== want.picked_target)
					report_mismatch("picked_target", result.picked_target, want.picked_target);
				if (result.picked_served !== want.picked_served)
					report_mismatch("picked_served", result.picked_served, want.picked_served);
				if (result.picked_priority !== want.picked_priority)
					report_mismatch("picked_priority", result.picked_priority,
						want.picked_priority);
				if (result.queue_count !== want.queue_count)
					report_mismatch("queue_count", result.queue_count, want.queue_count);
			end
		end
	end

	// watchdog: any accepted transaction, result or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || policy_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int items_sent;
		int phase;
		int enq_pct;
		int phase_len;
		items_sent = 0;
		phase      = 0;

		// reset held from time zero, released once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_policy(dir_rows[r].pol);
			end else begin
				repeat (dir_rows[r].rep) begin
					issue_command(dir_rows[r].rnd ? random_task_entry(100) : dir_rows[r].stim,
						dir_rows[r].typed, dir_rows[r].want);
					pace_sender();
				end
			end
		end

		// random phases: first eight walk every policy code, later ones pick at random;
		// the enqueue share swings so the queue both fills up and runs dry
		while (items_sent < RANDOM_ITEMS) begin
			write_policy((phase < 8) ? 3'(phase) : 3'($urandom_range(7)));
			case ($urandom_range(2))
				0: enq_pct = 25;
				1: enq_pct = 50;
				default: enq_pct = 80;
			endcase
			phase_len = $urandom_range(90, 30);
			repeat (phase_len) begin
				issue_command(random_task_entry(enq_pct), 1'b0, NO_WANT);
				pace_sender();
				items_sent++;
			end
			phase++;
		end

		// drain: wait for every outstanding result, then a quiet tail for strays
		start <= 1'b0;
		do @(posedge clk); while (predicted_outcomes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predicted_outcomes.size() != 0)
			report_mismatch("results outstanding", predicted_outcomes.size(), 0);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rqpd_pkg.sv
hdl/rqpd_ram.sv
hdl/rqpd_ctrl.sv
hdl/rqpd_dp.sv
hdl/ready_queue_policy_dispatcher_unit.sv
sim/tb_top.sv
